// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the Q15 FIR filter; clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QFIR_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/qfir_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qfir_pkg
// Shared types and constants of the Q15 FIR filter.
// ---------------------------------------------------------------------------
package qfir_pkg;

    localparam int DATA_W      = 16;
    localparam int INDEX_W     = 5;
    localparam int TAP_COUNT_W = 6;
    localparam int ACC_W       = 32;
    localparam int OUT_SHIFT   = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 6'd32;
    localparam logic signed [ACC_W-1:0] ACC_ROUND      = 32'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic coef_we;
        logic start;
        logic issue;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/qfir_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qfir_in_if
// Input channel: sample or coefficient-load words.
// ---------------------------------------------------------------------------
interface qfir_in_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [qfir_pkg::INDEX_W-1:0]         tap_index;
    logic signed [qfir_pkg::DATA_W-1:0]   value;
    logic                                 block_end;

    modport source (
        output valid,
        input  ready,
        output operation,
        output tap_index,
        output value,
        output block_end
    );

    modport sink (
        input  valid,
        output ready,
        input  operation,
        input  tap_index,
        input  value,
        input  block_end
    );

endinterface

// ----- hdl/qfir_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qfir_out_if
// Output channel: filtered Q15 words.
// ---------------------------------------------------------------------------
interface qfir_out_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [qfir_pkg::DATA_W-1:0]   filtered;
    logic                                 block_end_out;

    modport source (
        output valid,
        input  ready,
        output filtered,
        output block_end_out
    );

    modport sink (
        input  valid,
        output ready,
        input  filtered,
        input  block_end_out
    );

endinterface

// ----- hdl/qfir_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qfir_datapath
// Coefficient and history memories, multiply stage, saturating accumulator
// and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qfir_datapath #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qfir_pkg::dp_cmd_t                   cmd,
    output qfir_pkg::dp_status_t                status,
    input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_addr,
    input  logic [$clog2(MAX_TAPS + 1)-1:0]     tap_total,
    input  logic [qfir_pkg::INDEX_W-1:0]        in_tap_index,
    input  logic signed [qfir_pkg::DATA_W-1:0]  in_value,
    input  logic                                in_block_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qfir_pkg::DATA_W-1:0]  out_filtered,
    output logic                                out_block_end
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int DW    = qfir_pkg::DATA_W;
    localparam int ACW   = qfir_pkg::ACC_W;
    localparam int SUM_W = ACW + 2;

    localparam logic signed [ACW-1:0] ACC_MAX = {1'b0, {(ACW-1){1'b1}}};
    localparam logic signed [ACW-1:0] ACC_MIN = {1'b1, {(ACW-1){1'b0}}};

    logic signed [DW-1:0]    coef_mem [MAX_TAPS];
    logic signed [DW-1:0]    hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]     hist_ok_reg;

    logic signed [DW-1:0]    coef_rd_reg;
    logic signed [DW-1:0]    hist_rd_reg;
    logic                    hist_rd_ok_reg;
    logic                    s1_valid_reg;
    logic                    s1_first_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    s2_valid_reg;
    logic signed [ACW-1:0]   prod_reg;
    logic signed [ACW-1:0]   acc_reg;
    logic signed [ACW-1:0]   acc_next;
    logic signed [DW-1:0]    sample_reg;
    logic                    block_end_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [DW-1:0]    out_filtered_reg;
    logic                    out_block_end_reg;

    logic                    coef_we;
    logic [AW-1:0]           coef_waddr;
    logic signed [DW-1:0]    tap_data;
    logic                    hist_we;
    logic [AW-1:0]           hist_waddr;
    logic [CW-1:0]           hist_wpos;
    logic signed [SUM_W-1:0] acc_sum;
    logic signed [ACW-1:0]   acc_sat;

    assign coef_we    = cmd.coef_we && (32'(in_tap_index) < MAX_TAPS);
    assign coef_waddr = AW'(in_tap_index);

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= in_value;
        end
        coef_rd_reg <= coef_mem[tap_addr];
    end

    // stage 1: tap 0 takes the new sample, the rest come from history
    assign tap_data   = s1_first_reg ? sample_reg : (hist_rd_ok_reg ? hist_rd_reg : '0);
    assign hist_wpos  = CW'(s1_addr_reg) + CW'(1);
    assign hist_we    = s1_valid_reg && (hist_wpos < tap_total);
    assign hist_waddr = s1_addr_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= tap_data;
        end
        hist_rd_reg <= hist_mem[tap_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_ok_reg    <= '0;
            hist_rd_ok_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (hist_we)
            begin
                hist_ok_reg[hist_waddr] <= 1'b1;
            end
            hist_rd_ok_reg <= hist_ok_reg[tap_addr];
            s1_valid_reg   <= cmd.issue;
            s2_valid_reg   <= s1_valid_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    // stage 2: saturating accumulate of twice the product
    always_comb
    begin
        acc_sum = SUM_W'(acc_reg) + (SUM_W'(prod_reg) <<< 1);
        if ((acc_sum[SUM_W-1:ACW-1] == '0) || (acc_sum[SUM_W-1:ACW-1] == '1))
        begin
            acc_sat = acc_sum[ACW-1:0];
        end
        else if (acc_sum[SUM_W-1])
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = ACC_MAX;
        end
    end

    always_comb
    begin
        priority if (cmd.start)
        begin
            acc_next = qfir_pkg::ACC_ROUND;
        end
        else if (s2_valid_reg)
        begin
            acc_next = acc_sat;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (tap_addr == '0);
        s1_addr_reg  <= tap_addr;
        prod_reg     <= ACW'(tap_data) * ACW'(coef_rd_reg);
        acc_reg      <= acc_next;
        if (cmd.start)
        begin
            sample_reg    <= in_value;
            block_end_reg <= in_block_end;
        end
        if (cmd.result_load)
        begin
            out_filtered_reg  <= DW'(acc_reg >>> qfir_pkg::OUT_SHIFT);
            out_block_end_reg <= block_end_reg;
        end
    end

    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_filtered  = out_filtered_reg;
    assign out_block_end = out_block_end_reg;

    `QFIR_ASSERT_NEXT(a_pipe_flow, s1_valid_reg, s2_valid_reg, "stage 2 lost a tap")
    `QFIR_ASSERT(a_drained_on_result, cmd.result_load, !status.pipe_busy, "result before drain")

endmodule

// ----- hdl/qfir_controller.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qfir_controller
// Tap count register and the sequencer that sweeps the taps of one sample.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qfir_controller #(
    parameter int MAX_TAPS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [qfir_pkg::TAP_COUNT_W-1:0]      cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_operation,
    output qfir_pkg::dp_cmd_t                     cmd,
    input  qfir_pkg::dp_status_t                  status,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] tap_addr,
    output logic [$clog2(MAX_TAPS + 1)-1:0]       tap_total
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    qfir_pkg::ctrl_state_t state_reg;
    qfir_pkg::ctrl_state_t state_next;
    logic [qfir_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic [CW-1:0] n_sel;

    always_comb
    begin
        if (32'(tap_count_reg) > MAX_TAPS)
        begin
            n_sel = CW'(MAX_TAPS);
        end
        else
        begin
            n_sel = CW'(tap_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qfir_pkg::ST_IDLE;
            tap_count_reg <= qfir_pkg::TAP_COUNT_RESET;
            idx_reg       <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            if (cfg_wr_en)
            begin
                tap_count_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            qfir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_operation)
                        qfir_pkg::OP_LOAD:
                        begin
                            cmd.coef_we = 1'b1;
                        end
                        qfir_pkg::OP_SAMPLE:
                        begin
                            cmd.start  = 1'b1;
                            n_next     = n_sel;
                            idx_next   = '0;
                            state_next = (n_sel == '0) ? qfir_pkg::ST_DRAIN : qfir_pkg::ST_RUN;
                        end
                        default:
                        begin
                            state_next = qfir_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            qfir_pkg::ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (idx_reg == (n_reg - CW'(1)))
                begin
                    state_next = qfir_pkg::ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            qfir_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = qfir_pkg::ST_DONE;
                end
            end
            qfir_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = qfir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qfir_pkg::ST_IDLE;
            end
        endcase
    end

    assign tap_addr  = idx_reg[AW-1:0];
    assign tap_total = n_reg;

    `QFIR_ASSERT(a_result_has_room, cmd.result_load, status.out_free && !status.pipe_busy, "result loaded over a waiting word")
    `QFIR_ASSERT(a_run_in_range, state_reg == qfir_pkg::ST_RUN, (idx_reg < n_reg) && (n_reg != '0), "tap index outside active taps")
    `QFIR_ASSERT_NEXT(a_start_leaves_idle, cmd.start, !in_ready, "sample start did not block input")

endmodule

// ----- hdl/q15_fir_filter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q15_fir_filter
// Direct-form FIR filter on signed Q15 samples with a loadable tap store.
// ---------------------------------------------------------------------------
// A coefficient-load word gives no output. A sample word holds off further
// input until its result is loaded, n = min(tap_count, MAX_TAPS), and the
// tap walk is skipped when n is zero: one shared multiply-accumulate unit
// walks the taps one per cycle, fed by one-read one-write coefficient and
// history memories; after the last tap the multiply and accumulate stages
// drain first and only then is the output register loaded. The load waits
// while the previous word still sits unaccepted in that register. A finished
// word waits in that register while the next input word is taken.
// Coefficients must be loaded before use; history starts at zero.

module q15_fir_filter #(
    parameter int MAX_TAPS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [qfir_pkg::TAP_COUNT_W-1:0]  cfg_wr_data,
    qfir_in_if.sink                           items,
    qfir_out_if.source                        results
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    qfir_pkg::dp_cmd_t    cmd;
    qfir_pkg::dp_status_t status;
    logic [AW-1:0]        tap_addr;
    logic [CW-1:0]        tap_total;

    qfir_controller #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (items.valid),
        .in_ready     (items.ready),
        .in_operation (items.operation),
        .cmd          (cmd),
        .status       (status),
        .tap_addr     (tap_addr),
        .tap_total    (tap_total)
    );

    qfir_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .tap_addr      (tap_addr),
        .tap_total     (tap_total),
        .in_tap_index  (items.tap_index),
        .in_value      (items.value),
        .in_block_end  (items.block_end),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .out_filtered  (results.filtered),
        .out_block_end (results.block_end_out)
    );

endmodule

// ----- verif/q15_fir_filter_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q15_fir_filter_tb
// Self-checking bench for the Q15 direct-form FIR filter.
// A queue-fed driver loads taps and streams samples. An in-order predictor
// keeps its own delay line, tap store and tap count, and each filtered word
// is checked against it. The tap count is swept between phases, including
// zero and values beyond the tap store. Both sides idle at random.
// ---------------------------------------------------------------------------
module q15_fir_filter_tb;

    localparam int STORE_DEPTH = 32;
    localparam int DW          = qfir_pkg::DATA_W;
    localparam int IW          = qfir_pkg::INDEX_W;
    localparam int TCW         = qfir_pkg::TAP_COUNT_W;
    localparam int SETTLE      = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 50;

    typedef enum logic [1:0] {
        JOB_WORD,
        JOB_TAPS,
        JOB_DRAIN
    } job_kind_t;

    typedef struct {
        job_kind_t            kind;
        logic                 op;
        logic [IW-1:0]        idx;
        logic signed [DW-1:0] val;
        logic                 be;
        logic [TCW-1:0]       taps;
    } feed_job_t;

    typedef struct packed {
        logic signed [DW-1:0] filtered;
        logic                 block_end;
    } filt_word_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    logic [TCW-1:0] cfg_wr_data;

    qfir_in_if  in_ch();
    qfir_out_if out_ch();

    q15_fir_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .items       (in_ch),
        .results     (out_ch)
    );

    feed_job_t            feed_q[$];
    filt_word_t           filtered_due[$];
    logic signed [DW-1:0] hist_m [STORE_DEPTH];
    logic signed [DW-1:0] coef_m [STORE_DEPTH];
    logic [TCW-1:0]       taps_m;
    logic                 word_taken;
    bit                   failed;
    bit                   held_off;
    int                   cycle_cnt;
    int                   results_seen;
    int                   gap_left;
    int                   settle_left;
    int                   stall_left;
    int                   hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL q15_fir_filter");
            $finish;
        end
    end

    // random idle gaps; calm stretches: no idling on either side
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_cnt % 3000) < 700)
            return 0;
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [DW-1:0] rand_q15();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic void push_word(logic op, logic [IW-1:0] idx,
                                      logic signed [DW-1:0] val, logic be);
        feed_job_t j;
        j.kind = JOB_WORD;
        j.op   = op;
        j.idx  = idx;
        j.val  = val;
        j.be   = be;
        j.taps = '0;
        feed_q.push_back(j);
    endfunction

    function automatic void push_job(job_kind_t kind, logic [TCW-1:0] taps);
        feed_job_t j;
        j.kind = kind;
        j.op   = qfir_pkg::OP_SAMPLE;
        j.idx  = '0;
        j.val  = '0;
        j.be   = 1'b0;
        j.taps = taps;
        feed_q.push_back(j);
    endfunction

    function automatic void fir_accept(logic op, logic [IW-1:0] idx,
                                       logic signed [DW-1:0] val, logic be);
        int         n;
        int         t;
        longint     acc;
        filt_word_t w;
        if (op == qfir_pkg::OP_LOAD)
        begin
            coef_m[idx] = val;
        end
        else
        begin
            n = (taps_m > STORE_DEPTH) ? STORE_DEPTH : int'(taps_m);
            hist_m[0] = val;
            acc = qfir_pkg::ACC_ROUND;
            for (t = 0; t < n; t++)
            begin
                acc += 2 * (longint'(hist_m[t]) * longint'(coef_m[t]));
                if (acc > 64'sh7FFF_FFFF)
                    acc = 64'sh7FFF_FFFF;
                else if (acc < -64'sh8000_0000)
                    acc = -64'sh8000_0000;
            end
            for (t = n - 1; t > 0; t--)
                hist_m[t] = hist_m[t - 1];
            hist_m[0] = '0;
            w.filtered  = acc[qfir_pkg::ACC_W-1:qfir_pkg::OUT_SHIFT];
            w.block_end = be;
            filtered_due.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        filt_word_t due_w;
        if (rst_n)
        begin
            word_taken <= in_ch.valid && in_ch.ready;
            if (cfg_wr_en)
                taps_m = cfg_wr_data;
            if (in_ch.valid && in_ch.ready)
                fir_accept(in_ch.operation, in_ch.tap_index, in_ch.value, in_ch.block_end);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (filtered_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual filtered %h end %b",
                             $time, out_ch.filtered, out_ch.block_end_out);
                    failed = 1'b1;
                end
                else
                begin
                    due_w = filtered_due.pop_front();
                    if (out_ch.filtered !== due_w.filtered)
                    begin
                        $display("%0t: filtered mismatch, expected %h, actual %h",
                                 $time, due_w.filtered, out_ch.filtered);
                        failed = 1'b1;
                    end
                    if (out_ch.block_end_out !== due_w.block_end)
                    begin
                        $display("%0t: block_end_out mismatch, expected %b, actual %b",
                                 $time, due_w.block_end, out_ch.block_end_out);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : feeder
        logic      nv;
        logic      nwe;
        feed_job_t job;
        nv  = in_ch.valid;
        nwe = 1'b0;
        if (rst_n)
        begin
            if (in_ch.valid && word_taken)
                nv = 1'b0;
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (feed_q.size() > 0)
                begin
                    job = feed_q[0];
                    if (job.kind == JOB_WORD)
                    begin
                        void'(feed_q.pop_front());
                        nv = 1'b1;
                        in_ch.operation <= job.op;
                        in_ch.tap_index <= job.idx;
                        in_ch.value     <= job.val;
                        in_ch.block_end <= job.be;
                        gap_left = pick_gap();
                    end
                    else if (filtered_due.size() != 0)
                        settle_left = SETTLE;
                    else if (settle_left > 0)
                        settle_left--;
                    else
                    begin
                        void'(feed_q.pop_front());
                        if (job.kind == JOB_TAPS)
                        begin
                            nwe = 1'b1;
                            cfg_wr_data <= job.taps;
                        end
                        settle_left = SETTLE;
                    end
                end
            end
            in_ch.valid <= nv;
            cfg_wr_en   <= nwe;
        end
    end

    always @(negedge clk)
    begin : sink_side
        logic nr;
        nr = 1'b1;
        if (rst_n)
        begin
            // one long hold-off while the sender keeps offering
            if (!held_off && results_seen >= 100 && in_ch.valid && feed_q.size() > 60)
            begin
                held_off  = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nr = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nr = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = pick_gap();
                nr = (stall_left == 0);
            end
            out_ch.ready <= nr;
        end
    end

    initial
    begin
        int             i;
        int             p;
        int             k;
        logic [TCW-1:0] phase_taps [8];
        phase_taps = '{6'd32, 6'd1, 6'd7, 6'd0, 6'd32, 6'd1, 6'd63, 6'd19};

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = qfir_pkg::OP_SAMPLE;
        in_ch.tap_index = '0;
        in_ch.value     = '0;
        in_ch.block_end = 1'b0;
        out_ch.ready    = 1'b0;
        word_taken      = 1'b0;
        taps_m          = qfir_pkg::TAP_COUNT_RESET;
        failed          = 1'b0;
        held_off        = 1'b0;
        cycle_cnt       = 0;
        results_seen    = 0;
        gap_left        = 0;
        settle_left     = SETTLE;
        stall_left      = 0;
        hold_left       = 0;
        for (i = 0; i < STORE_DEPTH; i++)
        begin
            hist_m[i] = '0;
            coef_m[i] = '0;
        end

        // every tap is written before the first sample
        for (i = 0; i < STORE_DEPTH; i++)
            push_word(qfir_pkg::OP_LOAD, IW'(i), (i == 0) ? 16'sh8000 : rand_q15(),
                      1'($urandom_range(0, 1)));

        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b0);
        push_word(qfir_pkg::OP_SAMPLE, 5'd31, 16'sh8000, 1'b1);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh0000, 1'b0);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'shFFFF, 1'b1);

        // full-scale product saturates high
        push_job(JOB_TAPS, 6'd1);
        push_word(qfir_pkg::OP_LOAD, 5'd0, 16'sh8000, 1'b0);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh8000, 1'b1);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b0);

        // two taps saturate low
        push_job(JOB_TAPS, 6'd2);
        push_word(qfir_pkg::OP_LOAD, 5'd1, 16'sh8000, 1'b1);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b0);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b1);

        push_job(JOB_TAPS, 6'd0);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh3039, 1'b1);

        // counts above the store clamp to its size
        push_job(JOB_TAPS, 6'd63);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh7FFF, 1'b0);
        push_word(qfir_pkg::OP_SAMPLE, '0, 16'sh8000, 1'b1);
        push_job(JOB_TAPS, 6'd40);
        push_word(qfir_pkg::OP_SAMPLE, '0, rand_q15(), 1'b0);

        for (p = 0; p < 8; p++)
        begin
            push_job(JOB_TAPS, phase_taps[p]);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                if (p == 5 && k == PHASE_WORDS / 2)
                    push_job(JOB_DRAIN, '0);
                if ($urandom_range(0, 99) < 15)
                    push_word(qfir_pkg::OP_LOAD, IW'($urandom), rand_q15(),
                              1'($urandom_range(0, 1)));
                else
                    push_word(qfir_pkg::OP_SAMPLE, IW'($urandom), rand_q15(),
                              ($urandom_range(0, 7) == 0));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_ch.valid || filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (filtered_due.size() != 0)
        begin
            $display("%0t: %0d filtered words never arrived, expected %h, actual none",
                     $time, filtered_due.size(), filtered_due[0].filtered);
            failed = 1'b1;
        end

        if (!failed)
            $display("PASS q15_fir_filter");
        else
            $display("FAIL q15_fir_filter");
        $finish;
    end

endmodule
